// File: sv/klist_pkg.sv
`default_nettype none

package klist_pkg;

	localparam int DEPTH = 16;
	localparam int KEY_W = 31;
	localparam int PAY_W = 64;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_FIND   = 2'd2;
	localparam logic [1:0] REQ_LIST   = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NOTFOUND = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;

	// cell load modes
	localparam logic [1:0] MODE_HOLD = 2'd0;
	localparam logic [1:0] MODE_PUSH = 2'd1; // take record from the newer neighbor
	localparam logic [1:0] MODE_PULL = 2'd2; // take record from the older neighbor
	localparam logic [1:0] MODE_WRAP = 2'd3; // take record from the head cell

	typedef struct packed {
		logic [1:0]       req_type;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [KEY_W-1:0] found_key;
		logic [PAY_W-1:0] found_payload;
		logic [CNT_W-1:0] entry_count;
		logic             last;
	} res_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} rec_t;

endpackage

`default_nettype wire

// File: sv/klist_cell.sv
`default_nettype none

module klist_cell import klist_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [1:0]       mode,
	input  wire rec_t             prev_rec,
	input  wire logic             prev_valid,
	input  wire rec_t             next_rec,
	input  wire logic             next_valid,
	input  wire rec_t             head_rec,
	input  wire logic [KEY_W-1:0] cmp_key,
	output rec_t                  rec,
	output logic                  valid,
	output logic                  hit
);

	rec_t rec_q;
	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (mode)
				MODE_PUSH: valid_q <= prev_valid;
				MODE_PULL: valid_q <= next_valid;
				default:   valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (mode)
			MODE_PUSH: rec_q <= prev_rec;
			MODE_PULL: rec_q <= next_rec;
			MODE_WRAP: rec_q <= head_rec;
			default:   rec_q <= rec_q;
		endcase
	end

	assign rec   = rec_q;
	assign valid = valid_q;
	assign hit   = valid_q && (rec_q.key == cmp_key);

endmodule

`default_nettype wire

// File: sv/keyed_record_list.sv
`default_nettype none

// Ordered store of up to DEPTH key/payload records, newest first, held in a
// chain of cells. A transaction is taken when start is high and busy is low;
// each result shows on result for one cycle with done high and cannot be
// stalled. Insert answers in the cycle after it is taken, and a new transaction
// may be taken in that same cycle. For find and remove, all cells compare the
// key when the transaction is taken, the next cycle picks the newest hit and,
// for remove, closes the gap. List gives the records one result at a time,
// newest first (an empty store gives a single not-found result): the chain
// rotates by one cell a cycle and the head cell feeds the output, so the order
// is restored when it ends.
module keyed_record_list import klist_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      done,
	output res_t      result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SEL  = 2'd1;
	localparam logic [1:0] ST_LIST = 2'd2;

	logic [1:0]       state_q;
	req_t             req_q;
	logic [DEPTH-1:0] hit_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] left_q;
	logic             done_q;
	res_t             res_q;

	rec_t             rec_v [DEPTH];
	logic [DEPTH-1:0] valid_v;
	logic [DEPTH-1:0] hit_v;
	logic [DEPTH-1:0] next_valid_v;
	logic [1:0]       mode_v [DEPTH];

	logic             accept;
	logic             full;
	logic             any_hit;
	logic [DEPTH-1:0] first_hit;
	logic [DEPTH-1:0] from_hit;
	rec_t             sel_rec;
	rec_t             new_rec;
	res_t             res_d;
	logic             res_ld;
	logic [DEPTH-1:0] cnt_mask;

	assign accept       = start && !busy;
	assign full         = (cnt_q == CNT_W'(DEPTH));
	assign new_rec      = '{key: req.key, payload: req.payload};
	assign next_valid_v = valid_v >> 1;

	// newest hit is the lowest set bit; cells from there on close the gap
	assign any_hit   = |hit_q;
	assign first_hit = hit_q & (~hit_q + DEPTH'(1));
	assign from_hit  = any_hit ? ~(first_hit - DEPTH'(1)) : '0;

	always_comb begin
		sel_rec = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_rec = sel_rec | (first_hit[i] ? rec_v[i] : '0);
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			mode_v[i] = MODE_HOLD;
			if (accept && req.req_type == REQ_INSERT && !full) begin
				mode_v[i] = MODE_PUSH;
			end else if (state_q == ST_SEL && req_q.req_type == REQ_REMOVE && from_hit[i]) begin
				mode_v[i] = MODE_PULL;
			end else if (state_q == ST_LIST && valid_v[i]) begin
				mode_v[i] = next_valid_v[i] ? MODE_PULL : MODE_WRAP;
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		rec_t prev_rec;
		logic prev_valid;
		rec_t next_rec;

		if (g == 0) begin : g_head
			assign prev_rec   = new_rec;
			assign prev_valid = 1'b1;
		end else begin : g_body
			assign prev_rec   = rec_v[g-1];
			assign prev_valid = valid_v[g-1];
		end

		if (g == DEPTH - 1) begin : g_tail
			assign next_rec = rec_v[g];
		end else begin : g_inner
			assign next_rec = rec_v[g+1];
		end

		klist_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.mode       (mode_v[g]),
			.prev_rec   (prev_rec),
			.prev_valid (prev_valid),
			.next_rec   (next_rec),
			.next_valid (next_valid_v[g]),
			.head_rec   (rec_v[0]),
			.cmp_key    (req.key),
			.rec        (rec_v[g]),
			.valid      (valid_v[g]),
			.hit        (hit_v[g])
		);
	end

	always_comb begin
		res_ld = 1'b0;
		res_d  = '0;
		if (accept && req.req_type == REQ_INSERT) begin
			res_ld = 1'b1;
			res_d.last = 1'b1;
			if (full) begin
				res_d.status      = STAT_FULL;
				res_d.entry_count = cnt_q;
			end else begin
				res_d.status        = STAT_OK;
				res_d.found_key     = req.key;
				res_d.found_payload = req.payload;
				res_d.entry_count   = cnt_q + CNT_W'(1);
			end
		end else if (accept && req.req_type == REQ_LIST && cnt_q == '0) begin
			res_ld = 1'b1;
			res_d.status = STAT_NOTFOUND;
			res_d.last   = 1'b1;
		end else if (state_q == ST_SEL) begin
			res_ld = 1'b1;
			res_d.last = 1'b1;
			if (any_hit) begin
				res_d.status        = STAT_OK;
				res_d.found_key     = sel_rec.key;
				res_d.found_payload = sel_rec.payload;
				res_d.entry_count   = (req_q.req_type == REQ_REMOVE) ? cnt_q - CNT_W'(1) : cnt_q;
			end else begin
				res_d.status      = STAT_NOTFOUND;
				res_d.entry_count = cnt_q;
			end
		end else if (state_q == ST_LIST) begin
			res_ld = 1'b1;
			res_d.status        = STAT_OK;
			res_d.found_key     = rec_v[0].key;
			res_d.found_payload = rec_v[0].payload;
			res_d.entry_count   = cnt_q;
			res_d.last          = (left_q == CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			left_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= res_ld;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_INSERT: begin
								if (!full) cnt_q <= cnt_q + CNT_W'(1);
							end
							REQ_LIST: begin
								if (cnt_q != '0) begin
									state_q <= ST_LIST;
									left_q  <= cnt_q;
								end
							end
							default: state_q <= ST_SEL;
						endcase
					end
				end
				ST_SEL: begin
					if (req_q.req_type == REQ_REMOVE && any_hit) cnt_q <= cnt_q - CNT_W'(1);
					state_q <= ST_IDLE;
				end
				ST_LIST: begin
					left_q <= left_q - CNT_W'(1);
					if (left_q == CNT_W'(1)) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			hit_q <= hit_v;
		end
		if (res_ld) res_q <= res_d;
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cnt_mask[i] = (CNT_W'(i) < cnt_q);
		end
	end

	// occupied cells always form a prefix whose length is the count
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_LIST |-> valid_v == cnt_mask)
		else $error("cell valid bits disagree with entry count");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_sel_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEL |=> done && result.last)
		else $error("search did not produce a final result");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == STAT_FULL |-> result.entry_count == CNT_W'(DEPTH))
		else $error("full reported on a store with free cells");

	a_list_restore: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LIST && left_q == CNT_W'(1) |=> state_q == ST_IDLE && done && result.last)
		else $error("list did not end on its last record");

endmodule

`default_nettype wire
